FILE: rtl/viewport_nearest_scaler_address_unit_defines.svh
// ----------------------------------------------------------------------------
// Viewport nearest scaler address unit: assertion macros
// Concurrent checks clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef VIEWPORT_NEAREST_SCALER_ADDRESS_UNIT_DEFINES_SVH
`define VIEWPORT_NEAREST_SCALER_ADDRESS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define VNSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define VNSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define VNSA_ASSERT_IMP(lbl, ante, cons, msg)
`define VNSA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/vnsa_pkg.sv
// ----------------------------------------------------------------------------
// Viewport nearest scaler address unit: shared package
// Field widths, register indexes, status codes and the reciprocal table.
// ----------------------------------------------------------------------------
package vnsa_pkg;

	localparam int POS_W       = 16;
	localparam int SCALE_PX_W  = 8;
	localparam int SCALE_W     = 4;
	localparam int SCREEN_W    = 17;
	localparam int SRC_INDEX_W = 24;
	localparam int CLAMP_W     = 18;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Reciprocal of the pixel scale, fixed point with RECIP_FRAC fraction bits.
	// Rounded up, it gives exact quotients for numerators below 2**16.
	localparam int RECIP_FRAC  = 24;
	localparam int RECIP_W     = RECIP_FRAC + 1;
	localparam int RECIP_DEPTH = 1 << SCALE_PX_W;

	localparam logic [CFG_INDEX_W-1:0] CFG_ART_WIDTH    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ART_HEIGHT   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WORLD_WIDTH  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_WORLD_HEIGHT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ART_SCALE    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y     = 3'd5;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_EMPTY   = 2'd1,
		STATUS_OUTSIDE = 2'd2
	} status_t;

	typedef struct packed {
		logic zero_req;
		logic outside;
	} flags_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} win_en_t;

	typedef logic [RECIP_W-1:0] recip_tab_t [RECIP_DEPTH];

	function automatic recip_tab_t build_recip_tab();
		recip_tab_t  t;
		int unsigned num;
		int unsigned rem;
		int unsigned quo;
		t[0] = '0;
		for (int d = 1; d < RECIP_DEPTH; d++) begin
			// rounded-up quotient of 2**RECIP_FRAC by d, one bit per pass
			num = (32'd1 << RECIP_FRAC) + 32'(d) - 32'd1;
			rem = '0;
			quo = '0;
			for (int b = RECIP_W - 1; b >= 0; b--) begin
				rem = (rem << 1) | ((num >> b) & 32'd1);
				quo = quo << 1;
				if (rem >= 32'(d)) begin
					rem = rem - 32'(d);
					quo = quo | 32'd1;
				end
			end
			t[d] = RECIP_W'(quo);
		end
		return t;
	endfunction

	localparam recip_tab_t RECIP_TAB = build_recip_tab();

endpackage

FILE: rtl/viewport_nearest_scaler_address_unit.sv
// ----------------------------------------------------------------------------
// Viewport nearest scaler address unit
// Source art address and screen position for each output pixel of a
// nearest-neighbour viewport scaler.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one beat per output pixel, carrying
//   the camera, viewport size, pixel scale, destination and pixel position.
//   Output channel (out_valid / out_stall): one beat per input beat, in order,
//   with the source index, row, column, screen position and status.
//   Configuration channel (cfg_valid / cfg_ready): one register per beat,
//   always ready; write only while no beat is in flight.
//   A beat may enter every cycle while in_stall is low, so throughput is
//   one pixel per cycle. The pipeline has seven register stages.
//   Division by the pixel scale is a reciprocal table lookup in stage 1 and
//   a multiply in stage 2.
//   When the receiver stalls, the final stage holds its beat and the stall
//   ripples back only through occupied stages, so bubbles are squeezed out
//   before in_stall rises. Nothing is dropped or repeated.
//   Reset empties the pipeline and loads the register defaults: art and
//   room 240 by 240, art scale 1, room origin 0.
// ----------------------------------------------------------------------------
`include "viewport_nearest_scaler_address_unit_defines.svh"

module viewport_nearest_scaler_address_unit #(
	parameter int ART_DIM_BITS  = 12,
	parameter int VIEW_DIM_BITS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [vnsa_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [vnsa_pkg::CFG_DATA_W-1:0]        cfg_data,
	// input beats
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [vnsa_pkg::POS_W-1:0]      cam_x,
	input  logic signed [vnsa_pkg::POS_W-1:0]      cam_y,
	input  logic [VIEW_DIM_BITS-1:0]               view_w,
	input  logic [VIEW_DIM_BITS-1:0]               view_h,
	input  logic [vnsa_pkg::SCALE_PX_W-1:0]        scale_px,
	input  logic signed [vnsa_pkg::POS_W-1:0]      dest_x,
	input  logic signed [vnsa_pkg::POS_W-1:0]      dest_y,
	input  logic [VIEW_DIM_BITS-1:0]               pix_row,
	input  logic [VIEW_DIM_BITS-1:0]               pix_col,
	// output beats
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [vnsa_pkg::SRC_INDEX_W-1:0]       src_index,
	output logic [ART_DIM_BITS-1:0]                src_row,
	output logic [ART_DIM_BITS-1:0]                src_col,
	output logic signed [vnsa_pkg::SCREEN_W-1:0]   screen_x,
	output logic signed [vnsa_pkg::SCREEN_W-1:0]   screen_y,
	output vnsa_pkg::status_t                      status
);
	import vnsa_pkg::*;

	// Numerator width of every division by the pixel scale: the pixel offset
	// times the art scale is the widest.
	localparam int NUM_W  = VIEW_DIM_BITS + SCALE_W;
	localparam int PROD_W = 2 * ART_DIM_BITS;
	localparam int IDX_W  = (PROD_W > SRC_INDEX_W) ? PROD_W : SRC_INDEX_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [ART_DIM_BITS-1:0] art_width, art_height, world_width, world_height;
	logic [SCALE_W-1:0]      art_scale;
	logic signed [POS_W-1:0] world_origin_y;

	assign cfg_ready = 1'b1;

	vnsa_cfg_regs #(
		.ART_DIM_BITS (ART_DIM_BITS)
	) u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (cfg_valid && cfg_ready),
		.wr_index       (cfg_index),
		.wr_data        (cfg_data),
		.art_width      (art_width),
		.art_height     (art_height),
		.world_width    (world_width),
		.world_height   (world_height),
		.art_scale      (art_scale),
		.world_origin_y (world_origin_y)
	);

	// ------------------------------------------------------------------
	// Pipeline control: a stage loads when it is empty or its beat moves on
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7;
	win_en_t win_en;

	assign en_s7 = !v_s7 || !out_stall;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign in_stall  = !en_s1;
	assign out_valid = v_s7;
	assign win_en    = '{s3: en_s3, s4: en_s4, s5: en_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture the beat, look up the reciprocal, form numerators
	// ------------------------------------------------------------------
	logic [SCALE_W-1:0]       sc;
	flags_t                   flags;
	logic signed [SCREEN_W-1:0] scr_x, scr_y;
	logic signed [POS_W:0]    cam_y_rel;

	always_comb begin
		// art scale of zero acts as one
		sc = (art_scale == '0) ? SCALE_W'(1) : art_scale;
		flags.zero_req = (scale_px == '0) || (view_w == '0) || (view_h == '0);
		flags.outside  = (pix_row >= view_h) || (pix_col >= view_w);
		scr_x = SCREEN_W'(dest_x) + signed'(SCREEN_W'(pix_col));
		scr_y = SCREEN_W'(dest_y) + signed'(SCREEN_W'(pix_row));
		cam_y_rel = (POS_W + 1)'(cam_y) - (POS_W + 1)'(world_origin_y);
	end

	logic [RECIP_W-1:0]         recip_s1;
	logic [NUM_W-1:0]           num_w_s1, num_h_s1, num_c_s1, num_r_s1;
	logic signed [POS_W-1:0]    cam_x_s1;
	logic signed [POS_W:0]      cam_y_rel_s1;
	logic [SCALE_W-1:0]         sc_s1;
	flags_t                     flags_s1;
	logic signed [SCREEN_W-1:0] scr_x_s1, scr_y_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			recip_s1     <= RECIP_TAB[scale_px];
			// rounding-up division: add the divisor less one
			num_w_s1     <= NUM_W'(view_w) + NUM_W'(scale_px) - NUM_W'(1);
			num_h_s1     <= NUM_W'(view_h) + NUM_W'(scale_px) - NUM_W'(1);
			num_c_s1     <= NUM_W'(pix_col) * NUM_W'(sc);
			num_r_s1     <= NUM_W'(pix_row) * NUM_W'(sc);
			cam_x_s1     <= cam_x;
			cam_y_rel_s1 <= cam_y_rel;
			sc_s1        <= sc;
			flags_s1     <= flags;
			scr_x_s1     <= scr_x;
			scr_y_s1     <= scr_y;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: four quotients by the pixel scale
	// ------------------------------------------------------------------
	logic [NUM_W-1:0]           wvw_s2, wvh_s2, qc_s2, qr_s2;
	logic signed [POS_W-1:0]    cam_x_s2;
	logic signed [POS_W:0]      cam_y_rel_s2;
	logic [SCALE_W-1:0]         sc_s2;
	flags_t                     flags_s2;
	logic signed [SCREEN_W-1:0] scr_x_s2, scr_y_s2;

	vnsa_recip_div #(.NUM_W(NUM_W)) u_div_w (
		.clk (clk), .en (en_s2), .num (num_w_s1), .recip (recip_s1), .quo_s2 (wvw_s2)
	);
	vnsa_recip_div #(.NUM_W(NUM_W)) u_div_h (
		.clk (clk), .en (en_s2), .num (num_h_s1), .recip (recip_s1), .quo_s2 (wvh_s2)
	);
	vnsa_recip_div #(.NUM_W(NUM_W)) u_div_c (
		.clk (clk), .en (en_s2), .num (num_c_s1), .recip (recip_s1), .quo_s2 (qc_s2)
	);
	vnsa_recip_div #(.NUM_W(NUM_W)) u_div_r (
		.clk (clk), .en (en_s2), .num (num_r_s1), .recip (recip_s1), .quo_s2 (qr_s2)
	);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cam_x_s2     <= cam_x_s1;
			cam_y_rel_s2 <= cam_y_rel_s1;
			sc_s2        <= sc_s1;
			flags_s2     <= flags_s1;
			scr_x_s2     <= scr_x_s1;
			scr_y_s2     <= scr_y_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stages 3 to 5: camera clamp, source window, nearest pixel
	// ------------------------------------------------------------------
	logic [ART_DIM_BITS-1:0] row_s5, col_s5;
	status_t                 status_s5;

	vnsa_window #(
		.ART_DIM_BITS (ART_DIM_BITS),
		.NUM_W        (NUM_W)
	) u_window (
		.clk          (clk),
		.en           (win_en),
		.art_width    (art_width),
		.art_height   (art_height),
		.world_width  (world_width),
		.world_height (world_height),
		.cam_x_s2     (cam_x_s2),
		.cam_y_rel_s2 (cam_y_rel_s2),
		.sc_s2        (sc_s2),
		.flags_s2     (flags_s2),
		.wvw_s2       (wvw_s2),
		.wvh_s2       (wvh_s2),
		.qc_s2        (qc_s2),
		.qr_s2        (qr_s2),
		.row_s5       (row_s5),
		.col_s5       (col_s5),
		.status_s5    (status_s5)
	);

	// hold the screen position alongside the window stages
	logic signed [SCREEN_W-1:0] scr_x_s3, scr_y_s3, scr_x_s4, scr_y_s4;
	logic signed [SCREEN_W-1:0] scr_x_s5, scr_y_s5;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			scr_x_s3 <= scr_x_s2;
			scr_y_s3 <= scr_y_s2;
		end
		if (en_s4) begin
			scr_x_s4 <= scr_x_s3;
			scr_y_s4 <= scr_y_s3;
		end
		if (en_s5) begin
			scr_x_s5 <= scr_x_s4;
			scr_y_s5 <= scr_y_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: row times art width
	// ------------------------------------------------------------------
	logic [PROD_W-1:0]          prod_s6;
	logic [ART_DIM_BITS-1:0]    row_s6, col_s6;
	status_t                    status_s6;
	logic signed [SCREEN_W-1:0] scr_x_s6, scr_y_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			prod_s6   <= PROD_W'(row_s5) * PROD_W'(art_width);
			row_s6    <= row_s5;
			col_s6    <= col_s5;
			status_s6 <= status_s5;
			scr_x_s6  <= scr_x_s5;
			scr_y_s6  <= scr_y_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: add the column, output register
	// ------------------------------------------------------------------
	logic [IDX_W-1:0]           index_sum;
	logic [SRC_INDEX_W-1:0]     src_index_s7;
	logic [ART_DIM_BITS-1:0]    src_row_s7, src_col_s7;
	status_t                    status_s7;
	logic signed [SCREEN_W-1:0] scr_x_s7, scr_y_s7;

	assign index_sum = IDX_W'(prod_s6) + IDX_W'(col_s6);

	always_ff @(posedge clk) begin
		if (en_s7) begin
			src_index_s7 <= index_sum[SRC_INDEX_W-1:0];
			src_row_s7   <= row_s6;
			src_col_s7   <= col_s6;
			status_s7    <= status_s6;
			scr_x_s7     <= scr_x_s6;
			scr_y_s7     <= scr_y_s6;
		end
	end

	assign src_index = src_index_s7;
	assign src_row   = src_row_s7;
	assign src_col   = src_col_s7;
	assign screen_x  = scr_x_s7;
	assign screen_y  = scr_y_s7;
	assign status    = status_s7;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`VNSA_ASSERT_IMP(a_ok_inside_art, out_valid && (status == STATUS_OK),
		(src_col < art_width) && (src_row < art_height), "source pixel beyond art edge")
	`VNSA_ASSERT_IMP(a_no_draw_zero, out_valid && (status != STATUS_OK),
		(src_index == '0) && (src_row == '0) && (src_col == '0), "address on non-drawing beat")
	`VNSA_ASSERT_IMP(a_stall_only_full, in_stall, v_s1, "input stalled with first stage empty")
	`VNSA_ASSERT_NEXT(a_drain_to_out, v_s6 && !(out_valid && out_stall), out_valid,
		"beat in stage six did not reach the output")

endmodule

FILE: rtl/vnsa_cfg_regs.sv
// ----------------------------------------------------------------------------
// Viewport nearest scaler address unit: configuration registers
// Room, art and scale settings, written one register per beat.
// ----------------------------------------------------------------------------
module vnsa_cfg_regs #(
	parameter int ART_DIM_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [vnsa_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [vnsa_pkg::CFG_DATA_W-1:0]   wr_data,
	output logic [ART_DIM_BITS-1:0]           art_width,
	output logic [ART_DIM_BITS-1:0]           art_height,
	output logic [ART_DIM_BITS-1:0]           world_width,
	output logic [ART_DIM_BITS-1:0]           world_height,
	output logic [vnsa_pkg::SCALE_W-1:0]      art_scale,
	output logic signed [vnsa_pkg::POS_W-1:0] world_origin_y
);
	import vnsa_pkg::*;

	logic [ART_DIM_BITS-1:0] art_width_q, art_height_q, world_width_q, world_height_q;
	logic [SCALE_W-1:0]      art_scale_q;
	logic signed [POS_W-1:0] origin_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			art_width_q    <= ART_DIM_BITS'(240);
			art_height_q   <= ART_DIM_BITS'(240);
			world_width_q  <= ART_DIM_BITS'(240);
			world_height_q <= ART_DIM_BITS'(240);
			art_scale_q    <= SCALE_W'(1);
			origin_y_q     <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_ART_WIDTH:    art_width_q    <= ART_DIM_BITS'(wr_data);
				CFG_ART_HEIGHT:   art_height_q   <= ART_DIM_BITS'(wr_data);
				CFG_WORLD_WIDTH:  world_width_q  <= ART_DIM_BITS'(wr_data);
				CFG_WORLD_HEIGHT: world_height_q <= ART_DIM_BITS'(wr_data);
				CFG_ART_SCALE:    art_scale_q    <= wr_data[SCALE_W-1:0];
				CFG_ORIGIN_Y:     origin_y_q     <= signed'(wr_data[POS_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	assign art_width      = art_width_q;
	assign art_height     = art_height_q;
	assign world_width    = world_width_q;
	assign world_height   = world_height_q;
	assign art_scale      = art_scale_q;
	assign world_origin_y = origin_y_q;

endmodule

FILE: rtl/vnsa_recip_div.sv
// ----------------------------------------------------------------------------
// Viewport nearest scaler address unit: reciprocal divider lane
// Quotient by multiplication with a rounded-up reciprocal, one stage.
// ----------------------------------------------------------------------------
module vnsa_recip_div #(
	parameter int NUM_W = 14
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [NUM_W-1:0]             num,
	input  logic [vnsa_pkg::RECIP_W-1:0] recip,
	output logic [NUM_W-1:0]             quo_s2
);
	import vnsa_pkg::*;

	localparam int PROD_W = NUM_W + RECIP_W;

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(num) * PROD_W'(recip);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s2 <= prod[RECIP_FRAC +: NUM_W];
		end
	end

endmodule

FILE: rtl/vnsa_window.sv
// ----------------------------------------------------------------------------
// Viewport nearest scaler address unit: camera clamp and source window
// Stage 3 clamps the camera, stage 4 scales it to art pixels, stage 5
// picks the clamped source row and column and the status.
// ----------------------------------------------------------------------------
module vnsa_window #(
	parameter int ART_DIM_BITS = 12,
	parameter int NUM_W        = 14
) (
	input  logic                                 clk,
	input  vnsa_pkg::win_en_t                    en,
	input  logic [ART_DIM_BITS-1:0]              art_width,
	input  logic [ART_DIM_BITS-1:0]              art_height,
	input  logic [ART_DIM_BITS-1:0]              world_width,
	input  logic [ART_DIM_BITS-1:0]              world_height,
	input  logic signed [vnsa_pkg::POS_W-1:0]    cam_x_s2,
	input  logic signed [vnsa_pkg::POS_W:0]      cam_y_rel_s2,
	input  logic [vnsa_pkg::SCALE_W-1:0]         sc_s2,
	input  vnsa_pkg::flags_t                     flags_s2,
	input  logic [NUM_W-1:0]                     wvw_s2,
	input  logic [NUM_W-1:0]                     wvh_s2,
	input  logic [NUM_W-1:0]                     qc_s2,
	input  logic [NUM_W-1:0]                     qr_s2,
	output logic [ART_DIM_BITS-1:0]              row_s5,
	output logic [ART_DIM_BITS-1:0]              col_s5,
	output vnsa_pkg::status_t                    status_s5
);
	import vnsa_pkg::*;

	localparam int MW = (ART_DIM_BITS > NUM_W) ? ART_DIM_BITS : NUM_W;
	localparam int SW = ART_DIM_BITS + SCALE_W;
	localparam int RW = ((SW > NUM_W) ? SW : NUM_W) + 1;

	// Stage 3: camera clamp
	logic [ART_DIM_BITS-1:0]  max_x, max_y, cx, cy;
	logic signed [CLAMP_W-1:0] cam_x_e, cam_y_e, max_x_e, max_y_e;

	always_comb begin
		max_x = (MW'(world_width) > MW'(wvw_s2)) ?
			ART_DIM_BITS'(MW'(world_width) - MW'(wvw_s2)) : '0;
		max_y = (MW'(world_height) > MW'(wvh_s2)) ?
			ART_DIM_BITS'(MW'(world_height) - MW'(wvh_s2)) : '0;
		cam_x_e = CLAMP_W'(cam_x_s2);
		cam_y_e = CLAMP_W'(cam_y_rel_s2);
		max_x_e = signed'(CLAMP_W'(max_x));
		max_y_e = signed'(CLAMP_W'(max_y));
		if (cam_x_e < 0) begin
			cx = '0;
		end else if (cam_x_e > max_x_e) begin
			cx = max_x;
		end else begin
			cx = ART_DIM_BITS'(cam_x_e);
		end
		if (cam_y_e < 0) begin
			cy = '0;
		end else if (cam_y_e > max_y_e) begin
			cy = max_y;
		end else begin
			cy = ART_DIM_BITS'(cam_y_e);
		end
	end

	logic [ART_DIM_BITS-1:0] cx_s3, cy_s3;
	logic [SCALE_W-1:0]      sc_s3;
	logic [NUM_W-1:0]        qc_s3, qr_s3;
	flags_t                  flags_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			cx_s3    <= cx;
			cy_s3    <= cy;
			sc_s3    <= sc_s2;
			qc_s3    <= qc_s2;
			qr_s3    <= qr_s2;
			flags_s3 <= flags_s2;
		end
	end

	// Stage 4: window origin in art pixels
	logic [SW-1:0]    sx_s4, sy_s4;
	logic [NUM_W-1:0] qc_s4, qr_s4;
	flags_t           flags_s4;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			sx_s4    <= SW'(cx_s3) * SW'(sc_s3);
			sy_s4    <= SW'(cy_s3) * SW'(sc_s3);
			qc_s4    <= qc_s3;
			qr_s4    <= qr_s3;
			flags_s4 <= flags_s3;
		end
	end

	// Stage 5: nearest source pixel, clamped to the art edge
	logic          win_empty;
	logic [RW-1:0] row_sum, col_sum, row_lim, col_lim, row_sel, col_sel;
	status_t       status;

	always_comb begin
		win_empty = (SW'(art_width) <= sx_s4) || (SW'(art_height) <= sy_s4);
		row_sum   = RW'(sy_s4) + RW'(qr_s4);
		col_sum   = RW'(sx_s4) + RW'(qc_s4);
		row_lim   = RW'(art_height) - RW'(1);
		col_lim   = RW'(art_width) - RW'(1);
		row_sel   = (row_sum > row_lim) ? row_lim : row_sum;
		col_sel   = (col_sum > col_lim) ? col_lim : col_sum;
		if (flags_s4.zero_req || win_empty) begin
			status = STATUS_EMPTY;
		end else if (flags_s4.outside) begin
			status = STATUS_OUTSIDE;
		end else begin
			status = STATUS_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			status_s5 <= status;
			row_s5    <= (status == STATUS_OK) ? ART_DIM_BITS'(row_sel) : '0;
			col_s5    <= (status == STATUS_OK) ? ART_DIM_BITS'(col_sel) : '0;
		end
	end

endmodule
